// ===== rtl/ufcb_pkg.sv =====
// Shared constants and types for the UART flow control buffers block.
// Used by the top level; no dependencies.
package ufcb_pkg;

  // queue sizes and burst length
  localparam int RX_DEPTH  = 1024;
  localparam int TX_DEPTH  = 1024;
  localparam int TX_BURST  = 16;
  localparam int MAX_RES   = 16;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  // a burst never carries more bytes than one event may produce
  localparam int BURST_LIM = (TX_BURST < MAX_RES) ? TX_BURST : MAX_RES;
  localparam int BURST_W   = $clog2(BURST_LIM + 1);

  localparam int MARK_W = 11;
  localparam int CMP_W  = (RX_CW > MARK_W) ? RX_CW : MARK_W;

  localparam logic [7:0] XON_CH  = 8'd17;
  localparam logic [7:0] XOFF_CH = 8'd19;

  localparam logic [MARK_W-1:0] HIGH_MARK_RST = MARK_W'(816);
  localparam logic [MARK_W-1:0] LOW_MARK_RST  = MARK_W'(204);

  // event codes
  typedef enum logic [2:0] {
    REQ_LINE_BYTE  = 3'd0,
    REQ_HOST_READ  = 3'd1,
    REQ_HOST_WRITE = 3'd2,
    REQ_CTS_CHANGE = 3'd3,
    REQ_TX_READY   = 3'd4
  } req_t;

  // configuration port: register index lives in paddr[PADDR_W-1:2]
  localparam int PADDR_W = 5;
  localparam int RIDX_W  = PADDR_W - 2;

  localparam logic [RIDX_W-1:0] REG_XON_XOFF_EN = RIDX_W'(0);
  localparam logic [RIDX_W-1:0] REG_RTS_CTS_EN  = RIDX_W'(1);
  localparam logic [RIDX_W-1:0] REG_RX_HIGH     = RIDX_W'(2);
  localparam logic [RIDX_W-1:0] REG_RX_LOW      = RIDX_W'(3);
  localparam logic [RIDX_W-1:0] REG_FIFO_MODE   = RIDX_W'(4);

endpackage

// ===== rtl/ufcb_if.sv =====
// Valid/ready channel interfaces for event input and result output.
// Depends on nothing but plain logic types.
interface ufcb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic       cts_level;

  modport source (output valid, req_type, data_byte, cts_level, input ready);
  modport sink   (input valid, req_type, data_byte, cts_level, output ready);
endinterface

interface ufcb_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       rts_level;
  logic       input_blocked;
  logic       output_blocked;
  logic       write_rejected;
  logic       rx_overflow;
  logic       last;

  modport source (output valid, tx_valid, tx_byte, read_valid, read_byte, rts_level,
                  input_blocked, output_blocked, write_rejected, rx_overflow, last,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, read_valid, read_byte, rts_level,
                  input_blocked, output_blocked, write_rejected, rx_overflow, last,
                  output ready);
endinterface

// ===== rtl/uart_flow_control_buffers_unit.sv =====
// UART receive/transmit queues with XON/XOFF and RTS/CTS flow control.
// A new event is taken only while idle, once the previous event's last result is in the
// output register, which can stall on out_ch.ready; a transmit burst yields further bytes
// from the single read port of the transmit queue memory, one per output load.
// Reset (rst, synchronous): counts, pointers and flow flags clear, registers take
// their defaults; queue memories are not cleared, the counts guard every read that is used.
module uart_flow_control_buffers_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ufcb_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  ufcb_in_if.sink                          in_ch,
  ufcb_out_if.source                       out_ch
);

  localparam int RX_AW = ufcb_pkg::RX_AW;
  localparam int RX_CW = ufcb_pkg::RX_CW;
  localparam int TX_AW = ufcb_pkg::TX_AW;
  localparam int TX_CW = ufcb_pkg::TX_CW;
  localparam int BW    = ufcb_pkg::BURST_W;
  localparam int CW    = ufcb_pkg::CMP_W;
  localparam int MW    = ufcb_pkg::MARK_W;

  typedef enum logic {S_IDLE, S_OUT} state_t;

  // configuration
  logic          xen, ren, fifo;
  logic [MW-1:0] high_mark, low_mark;

  // queue state
  logic [RX_CW-1:0] rx_count;
  logic [RX_AW-1:0] rx_head;
  logic [TX_CW-1:0] tx_count;
  logic [TX_AW-1:0] tx_head;
  logic             bxoff, bcts, tx_idle, hold;

  // memories
  logic [7:0] rx_mem [ufcb_pkg::RX_DEPTH];
  logic [7:0] tx_mem [ufcb_pkg::TX_DEPTH];
  logic [7:0] rx_rdata, tx_rdata;

  // pending result
  state_t        state;
  logic          res_tx, res_tx_mem, res_rd, res_rej, res_ovf, res_last;
  logic [7:0]    res_tx_byte;
  logic [BW-1:0] burst_rem;

  // output register
  logic       out_valid, o_tx, o_rd, o_rej, o_ovf, o_last;
  logic       o_rts, o_ib, o_ob;
  logic [7:0] o_tx_byte, o_rd_byte;

  // event decode
  logic          in_fire, out_free, cfg_wr;
  logic          is_line, is_read, is_write, is_cts, is_txr;
  logic          xon_ctl, xoff_ctl, rx_full, line_norm, ovf, rd_en;
  logic          high_hit, low_hit, xoff_emit;
  logic          hw_do, hw_full, hw_ok, hw_kick, kx, kc, bs, pop, pop_fwd;
  logic [7:0]    hw_byte;
  logic [BW-1:0] lim;
  logic          burst_pop, tx_rd_en;
  logic [RX_AW:0] rx_sum;
  logic [TX_AW:0] tx_sum;
  logic [RX_AW-1:0] rx_tail, rx_head_inc;
  logic [TX_AW-1:0] tx_tail, tx_head_inc;
  logic [RX_CW-1:0] rx_cnt_inc, rx_cnt_dec;
  logic [TX_CW-1:0] tx_count_next;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  always_comb begin
    is_line  = (in_ch.req_type == ufcb_pkg::REQ_LINE_BYTE);
    is_read  = (in_ch.req_type == ufcb_pkg::REQ_HOST_READ);
    is_write = (in_ch.req_type == ufcb_pkg::REQ_HOST_WRITE);
    is_cts   = (in_ch.req_type == ufcb_pkg::REQ_CTS_CHANGE);
    is_txr   = (in_ch.req_type == ufcb_pkg::REQ_TX_READY);

    // circular pointers, generic depth: one compare-subtract on wrap
    rx_sum  = (RX_AW+1)'(rx_head) + (RX_AW+1)'(rx_count);
    rx_tail = (rx_sum >= (RX_AW+1)'(ufcb_pkg::RX_DEPTH)) ?
              RX_AW'(rx_sum - (RX_AW+1)'(ufcb_pkg::RX_DEPTH)) : RX_AW'(rx_sum);
    tx_sum  = (TX_AW+1)'(tx_head) + (TX_AW+1)'(tx_count);
    tx_tail = (tx_sum >= (TX_AW+1)'(ufcb_pkg::TX_DEPTH)) ?
              TX_AW'(tx_sum - (TX_AW+1)'(ufcb_pkg::TX_DEPTH)) : TX_AW'(tx_sum);
    rx_head_inc = (rx_head == RX_AW'(ufcb_pkg::RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
    tx_head_inc = (tx_head == TX_AW'(ufcb_pkg::TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
    rx_cnt_inc  = rx_count + 1'b1;
    rx_cnt_dec  = rx_count - 1'b1;

    // line byte
    xon_ctl   = xen && (in_ch.data_byte == ufcb_pkg::XON_CH);
    xoff_ctl  = xen && (in_ch.data_byte == ufcb_pkg::XOFF_CH);
    rx_full   = (rx_count == RX_CW'(ufcb_pkg::RX_DEPTH));
    line_norm = is_line && !xon_ctl && !xoff_ctl && !rx_full;
    ovf       = is_line && !xon_ctl && !xoff_ctl && rx_full;
    high_hit  = (CW'(rx_cnt_inc) == CW'(high_mark));
    xoff_emit = line_norm && high_hit && xen;

    // host read
    rd_en   = is_read && (rx_count != '0);
    low_hit = (CW'(rx_cnt_dec) == CW'(low_mark));

    // write into the transmit queue: host data or a queued XON
    hw_do   = is_write || (rd_en && low_hit && hold && xen);
    hw_byte = is_write ? in_ch.data_byte : ufcb_pkg::XON_CH;
    hw_full = (tx_count == TX_CW'(ufcb_pkg::TX_DEPTH));
    hw_ok   = hw_do && !hw_full;
    hw_kick = hw_ok && tx_idle && !bxoff && !bcts;

    // kick-starts on unblock, and burst start
    kx  = is_line && xon_ctl && tx_idle && bxoff && !bcts && (tx_count != '0);
    kc  = is_cts && ren && in_ch.cts_level && tx_idle && !bxoff && bcts &&
          (tx_count != '0);
    bs  = is_txr && !tx_idle && (tx_count != '0);
    pop = hw_kick || kx || kc || bs;
    // empty queue: the popped byte is the one written this cycle
    pop_fwd = hw_kick && (tx_count == '0);
    lim     = fifo ? BW'(ufcb_pkg::BURST_LIM) : BW'(1);

    tx_count_next = tx_count + TX_CW'(hw_ok) - TX_CW'(pop);

    burst_pop = (state == S_OUT) && out_free && !res_last;
    tx_rd_en  = (in_fire && pop) || burst_pop;
  end

  // queue memories: one write and one registered read port each
  always_ff @(posedge clk) begin
    if (in_fire && line_norm) begin
      rx_mem[rx_tail] <= in_ch.data_byte;
    end
    if (in_fire && rd_en) begin
      rx_rdata <= rx_mem[rx_head];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && hw_ok) begin
      tx_mem[tx_tail] <= hw_byte;
    end
    if (tx_rd_en) begin
      tx_rdata <= tx_mem[tx_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rx_count  <= '0;
      rx_head   <= '0;
      tx_count  <= '0;
      tx_head   <= '0;
      bxoff     <= 1'b0;
      bcts      <= 1'b0;
      tx_idle   <= 1'b1;
      hold      <= 1'b0;
      res_last  <= 1'b1;
      xen       <= 1'b0;
      ren       <= 1'b0;
      fifo      <= 1'b0;
      high_mark <= ufcb_pkg::HIGH_MARK_RST;
      low_mark  <= ufcb_pkg::LOW_MARK_RST;
    end else begin
      if (out_valid && out_ch.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_tx      <= pop || xoff_emit;
            res_tx_mem  <= pop && !pop_fwd;
            res_tx_byte <= xoff_emit ? ufcb_pkg::XOFF_CH : hw_byte;
            res_rd      <= rd_en;
            res_rej     <= hw_do && hw_full;
            res_ovf     <= ovf;
            res_last    <= !bs || (lim == BW'(1)) || (tx_count == TX_CW'(1));
            burst_rem   <= lim - 1'b1;
            tx_count    <= tx_count_next;
            if (pop) begin
              tx_head <= tx_head_inc;
            end
            if (hw_kick || kx || kc) begin
              tx_idle <= 1'b0;
            end
            if (line_norm) begin
              rx_count <= rx_cnt_inc;
              if (high_hit && (xen || ren)) begin
                hold <= 1'b1;
              end
            end
            if (rd_en) begin
              rx_count <= rx_cnt_dec;
              rx_head  <= rx_head_inc;
              if (low_hit && hold) begin
                hold <= 1'b0;
              end
            end
            if (is_line && xon_ctl) begin
              bxoff <= 1'b0;
            end
            if (is_line && xoff_ctl) begin
              bxoff   <= 1'b1;
              tx_idle <= 1'b1;
            end
            if (is_cts && ren) begin
              bcts <= !in_ch.cts_level;
              if (!in_ch.cts_level) begin
                tx_idle <= 1'b1;
              end
            end
            if (is_txr && !tx_idle && (tx_count <= TX_CW'(1))) begin
              tx_idle <= 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            o_tx      <= res_tx;
            o_tx_byte <= !res_tx ? 8'd0 : (res_tx_mem ? tx_rdata : res_tx_byte);
            o_rd      <= res_rd;
            o_rd_byte <= res_rd ? rx_rdata : 8'd0;
            o_rej     <= res_rej;
            o_ovf     <= res_ovf;
            o_last    <= res_last;
            // flow status as left by this transaction's event
            o_rts     <= !(hold && ren);
            o_ib      <= hold;
            o_ob      <= bxoff || bcts;
            if (!res_last) begin
              // next burst byte; its read overlaps the output load
              tx_head     <= tx_head_inc;
              tx_count    <= tx_count - 1'b1;
              burst_rem   <= burst_rem - 1'b1;
              res_tx      <= 1'b1;
              res_tx_mem  <= 1'b1;
              res_rd      <= 1'b0;
              res_last    <= (burst_rem == BW'(1)) || (tx_count == TX_CW'(1));
              if (tx_count == TX_CW'(1)) begin
                tx_idle <= 1'b1;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_wr) begin
        unique case (paddr[ufcb_pkg::PADDR_W-1:2])
          ufcb_pkg::REG_XON_XOFF_EN: begin
            xen   <= pwdata[0];
            hold  <= 1'b0;
            bxoff <= 1'b0;
          end
          ufcb_pkg::REG_RTS_CTS_EN: begin
            ren  <= pwdata[0];
            hold <= 1'b0;
            bcts <= 1'b0;
          end
          ufcb_pkg::REG_RX_HIGH:   high_mark <= pwdata[MW-1:0];
          ufcb_pkg::REG_RX_LOW:    low_mark  <= pwdata[MW-1:0];
          ufcb_pkg::REG_FIFO_MODE: fifo      <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[ufcb_pkg::PADDR_W-1:2])
      ufcb_pkg::REG_XON_XOFF_EN: prdata = 32'(xen);
      ufcb_pkg::REG_RTS_CTS_EN:  prdata = 32'(ren);
      ufcb_pkg::REG_RX_HIGH:     prdata = 32'(high_mark);
      ufcb_pkg::REG_RX_LOW:      prdata = 32'(low_mark);
      ufcb_pkg::REG_FIFO_MODE:   prdata = 32'(fifo);
      default:                   prdata = 32'd0;
    endcase
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.tx_valid       = o_tx;
  assign out_ch.tx_byte        = o_tx_byte;
  assign out_ch.read_valid     = o_rd;
  assign out_ch.read_byte      = o_rd_byte;
  assign out_ch.rts_level      = o_rts;
  assign out_ch.input_blocked  = o_ib;
  assign out_ch.output_blocked = o_ob;
  assign out_ch.write_rejected = o_rej;
  assign out_ch.rx_overflow    = o_ovf;
  assign out_ch.last           = o_last;

  a_rx_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= RX_CW'(ufcb_pkg::RX_DEPTH))
    else $error("receive count beyond queue depth");

  a_tx_count_bound: assert property (@(posedge clk) disable iff (rst)
    tx_count <= TX_CW'(ufcb_pkg::TX_DEPTH))
    else $error("transmit count beyond queue depth");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !o_last) |-> (state == S_OUT))
    else $error("non-final result with no further result pending");

  a_burst_byte: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !res_last) |-> (res_tx && tx_count != '0))
    else $error("burst continues with an empty transmit queue");

endmodule
